[src/ter_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the triangle rasterizer.
`default_nettype none
package ter_pkg;

  localparam int COORD_BITS_DEFAULT = 12;
  localparam int DIM_BITS           = 11;
  localparam int ADDR_BITS          = 22;
  localparam int COLOR_BITS         = 8;

  localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET  = 11'd640;
  localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = 11'd400;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_STEP = 1'b1;

  // Setup products pushed through the shared multiplier, one per cycle.
  localparam int NUM_TERMS    = 7;
  localparam int TERM_BITS    = 3;
  localparam int DRAIN_CYCLES = 2;
  localparam logic [TERM_BITS-1:0] TERM_E0_Y     = 3'd0;
  localparam logic [TERM_BITS-1:0] TERM_E0_X     = 3'd1;
  localparam logic [TERM_BITS-1:0] TERM_E1_Y     = 3'd2;
  localparam logic [TERM_BITS-1:0] TERM_E1_X     = 3'd3;
  localparam logic [TERM_BITS-1:0] TERM_E2_Y     = 3'd4;
  localparam logic [TERM_BITS-1:0] TERM_E2_X     = 3'd5;
  localparam logic [TERM_BITS-1:0] TERM_ROW_BASE = 3'd6;

  typedef struct packed {
    logic                 load;
    logic                 box;
    logic                 issue;
    logic [TERM_BITS-1:0] term;
    logic                 step;
    logic                 respond;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic at_end;
  } ctrl_status_t;

endpackage
`default_nettype wire

[src/ter_ctrl.sv]
// Controller state machine of the triangle rasterizer.
`default_nettype none
module ter_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 action,
  output logic                      busy,
  output ter_pkg::ctrl_cmd_t        cmd,
  input  wire ter_pkg::ctrl_status_t status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BOX   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_RUN   = 3'd4;

  logic [2:0]                    state;
  logic [2:0]                    state_next;
  logic [ter_pkg::TERM_BITS-1:0] cnt;
  logic [ter_pkg::TERM_BITS-1:0] cnt_next;
  logic                          accept;

  assign busy   = state inside {S_BOX, S_MUL, S_DRAIN};
  assign accept = start && !busy;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE, S_RUN: begin
        if (accept) begin
          cmd.respond = 1'b1;
          if (action == ter_pkg::ACTION_LOAD) begin
            cmd.load   = 1'b1;
            state_next = S_BOX;
          end else if (state == S_RUN) begin
            cmd.step = 1'b1;
            if (status.at_end) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      S_BOX: begin
        cmd.box    = 1'b1;
        cnt_next   = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (status.empty) begin
          state_next = S_IDLE;
        end else begin
          cmd.issue = 1'b1;
          cmd.term  = cnt;
          if (cnt == ter_pkg::TERM_BITS'(ter_pkg::NUM_TERMS - 1)) begin
            cnt_next   = '0;
            state_next = S_DRAIN;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (cnt == ter_pkg::TERM_BITS'(ter_pkg::DRAIN_CYCLES - 1)) begin
          state_next = S_RUN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
`default_nettype wire

[src/ter_datapath.sv]
// Datapath of the triangle rasterizer: box setup, shared multiplier and edge walker.
`default_nettype none
module ter_datapath #(
  parameter int COORD_BITS = ter_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire ter_pkg::ctrl_cmd_t                    cmd,
  output ter_pkg::ctrl_status_t                      status,
  input  wire logic signed [COORD_BITS-1:0]          x0,
  input  wire logic signed [COORD_BITS-1:0]          y0,
  input  wire logic signed [COORD_BITS-1:0]          x1,
  input  wire logic signed [COORD_BITS-1:0]          y1,
  input  wire logic signed [COORD_BITS-1:0]          x2,
  input  wire logic signed [COORD_BITS-1:0]          y2,
  input  wire logic [ter_pkg::COLOR_BITS-1:0]        color,
  input  wire logic                                  cfg_write,
  input  wire logic [ter_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [ter_pkg::DIM_BITS-1:0]          cfg_data,
  output logic                                       done,
  output logic                                       pixel_valid,
  output logic                                       write_enable,
  output logic [ter_pkg::ADDR_BITS-1:0]              pixel_address,
  output logic [ter_pkg::COLOR_BITS-1:0]             pixel_color,
  output logic                                       last
);

  localparam int W  = COORD_BITS;
  localparam int CW = ((W > ter_pkg::DIM_BITS) ? W : ter_pkg::DIM_BITS) + 2;
  localparam int SW = W + 1;
  localparam int OW = ((SW > ter_pkg::DIM_BITS + 1) ? SW : ter_pkg::DIM_BITS + 1);
  localparam int PW = 2 * OW;
  localparam int EW = 2 * W + 4;
  localparam int AW = ter_pkg::ADDR_BITS;

  logic [ter_pkg::DIM_BITS-1:0]   screen_width;
  logic [ter_pkg::DIM_BITS-1:0]   screen_height;

  logic signed [W-1:0]            vx [3];
  logic signed [W-1:0]            vy [3];
  logic [ter_pkg::COLOR_BITS-1:0] fill_color;

  logic [W-1:0]                   box_min_x;
  logic [W-1:0]                   box_max_x;
  logic [W-1:0]                   box_max_y;
  logic [W-1:0]                   cursor_x;
  logic [W-1:0]                   cursor_y;
  logic                           box_empty;
  logic signed [SW-1:0]           col_step [3];
  logic signed [SW-1:0]           row_step [3];

  logic signed [OW-1:0]           op_a;
  logic signed [OW-1:0]           op_b;
  logic [ter_pkg::TERM_BITS-1:0]  op_term;
  logic                           op_vld;
  logic signed [PW-1:0]           prod;
  logic [ter_pkg::TERM_BITS-1:0]  prod_term;
  logic                           prod_vld;

  logic signed [EW-1:0]           edge_row [3];
  logic signed [EW-1:0]           edge_val [3];
  logic [AW-1:0]                  row_base;

  // Bounding box setup.
  logic signed [CW-1:0] ex [3];
  logic signed [CW-1:0] ey [3];
  logic signed [CW-1:0] min_x, max_x, min_y, max_y;
  logic signed [CW-1:0] lim_x, lim_y;
  logic signed [CW-1:0] clip_min_x, clip_max_x, clip_min_y, clip_max_y;
  logic                 setup_empty;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ex[i] = CW'(vx[i]);
      ey[i] = CW'(vy[i]);
    end
    min_x = ex[0];
    max_x = ex[0];
    min_y = ey[0];
    max_y = ey[0];
    for (int i = 1; i < 3; i++) begin
      if (ex[i] < min_x) min_x = ex[i];
      if (ex[i] > max_x) max_x = ex[i];
      if (ey[i] < min_y) min_y = ey[i];
      if (ey[i] > max_y) max_y = ey[i];
    end
    lim_x       = $signed(CW'(screen_width) - CW'(1));
    lim_y       = $signed(CW'(screen_height) - CW'(1));
    clip_min_x  = min_x[CW-1] ? '0 : min_x;
    clip_min_y  = min_y[CW-1] ? '0 : min_y;
    clip_max_x  = (max_x > lim_x) ? lim_x : max_x;
    clip_max_y  = (max_y > lim_y) ? lim_y : max_y;
    setup_empty = (clip_min_x > clip_max_x) || (clip_min_y > clip_max_y);
  end

  // Operand select for the shared multiplier.
  logic signed [SW-1:0] cur_x_s;
  logic signed [SW-1:0] cur_y_s;
  logic signed [OW-1:0] sel_a;
  logic signed [OW-1:0] sel_b;

  assign cur_x_s = $signed({1'b0, cursor_x});
  assign cur_y_s = $signed({1'b0, cursor_y});

  always_comb begin
    case (cmd.term)
      ter_pkg::TERM_E0_Y: begin
        sel_a = OW'(row_step[0]);
        sel_b = OW'(cur_y_s - SW'(vy[1]));
      end
      ter_pkg::TERM_E0_X: begin
        sel_a = OW'(col_step[0]);
        sel_b = OW'(cur_x_s - SW'(vx[1]));
      end
      ter_pkg::TERM_E1_Y: begin
        sel_a = OW'(row_step[1]);
        sel_b = OW'(cur_y_s - SW'(vy[2]));
      end
      ter_pkg::TERM_E1_X: begin
        sel_a = OW'(col_step[1]);
        sel_b = OW'(cur_x_s - SW'(vx[2]));
      end
      ter_pkg::TERM_E2_Y: begin
        sel_a = OW'(row_step[2]);
        sel_b = OW'(cur_y_s - SW'(vy[0]));
      end
      ter_pkg::TERM_E2_X: begin
        sel_a = OW'(col_step[2]);
        sel_b = OW'(cur_x_s - SW'(vx[0]));
      end
      ter_pkg::TERM_ROW_BASE: begin
        sel_a = $signed(OW'(screen_width));
        sel_b = $signed(OW'(cursor_y));
      end
      default: begin
        sel_a = '0;
        sel_b = '0;
      end
    endcase
  end

  logic signed [EW-1:0] prod_ext;
  logic                 inside_all;
  logic                 at_end;

  assign prod_ext   = EW'(prod);
  assign inside_all = !edge_val[0][EW-1] && !edge_val[1][EW-1] && !edge_val[2][EW-1];
  assign at_end     = (cursor_x == box_max_x) && (cursor_y == box_max_y);

  assign status.empty  = box_empty;
  assign status.at_end = at_end;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ter_pkg::SCREEN_WIDTH_RESET;
      screen_height <= ter_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ter_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        ter_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Multiplier pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      op_vld   <= cmd.issue;
      prod_vld <= op_vld;
    end
  end

  always_ff @(posedge clk) begin
    op_a      <= sel_a;
    op_b      <= sel_b;
    op_term   <= cmd.term;
    prod      <= PW'(op_a) * PW'(op_b);
    prod_term <= op_term;
  end

  // Triangle state: load, box setup, product accumulation and pixel walk.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx[0]      <= x0;
      vy[0]      <= y0;
      vx[1]      <= x1;
      vy[1]      <= y1;
      vx[2]      <= x2;
      vy[2]      <= y2;
      fill_color <= color;
    end
    if (cmd.box) begin
      box_empty   <= setup_empty;
      box_min_x   <= clip_min_x[W-1:0];
      box_max_x   <= clip_max_x[W-1:0];
      box_max_y   <= clip_max_y[W-1:0];
      cursor_x    <= clip_min_x[W-1:0];
      cursor_y    <= clip_min_y[W-1:0];
      col_step[0] <= SW'(vy[1]) - SW'(vy[2]);
      row_step[0] <= SW'(vx[2]) - SW'(vx[1]);
      col_step[1] <= SW'(vy[2]) - SW'(vy[0]);
      row_step[1] <= SW'(vx[0]) - SW'(vx[2]);
      col_step[2] <= SW'(vy[0]) - SW'(vy[1]);
      row_step[2] <= SW'(vx[1]) - SW'(vx[0]);
    end else if (prod_vld) begin
      case (prod_term)
        ter_pkg::TERM_E0_Y: begin
          edge_row[0] <= prod_ext;
          edge_val[0] <= prod_ext;
        end
        ter_pkg::TERM_E0_X: begin
          edge_row[0] <= edge_row[0] + prod_ext;
          edge_val[0] <= edge_row[0] + prod_ext;
        end
        ter_pkg::TERM_E1_Y: begin
          edge_row[1] <= prod_ext;
          edge_val[1] <= prod_ext;
        end
        ter_pkg::TERM_E1_X: begin
          edge_row[1] <= edge_row[1] + prod_ext;
          edge_val[1] <= edge_row[1] + prod_ext;
        end
        ter_pkg::TERM_E2_Y: begin
          edge_row[2] <= prod_ext;
          edge_val[2] <= prod_ext;
        end
        ter_pkg::TERM_E2_X: begin
          edge_row[2] <= edge_row[2] + prod_ext;
          edge_val[2] <= edge_row[2] + prod_ext;
        end
        ter_pkg::TERM_ROW_BASE: begin
          row_base <= prod[AW-1:0];
        end
        default: ;
      endcase
    end else if (cmd.step) begin
      if (cursor_x != box_max_x) begin
        cursor_x <= cursor_x + 1'b1;
        for (int i = 0; i < 3; i++) begin
          edge_val[i] <= edge_val[i] + EW'(col_step[i]);
        end
      end else if (cursor_y != box_max_y) begin
        cursor_y <= cursor_y + 1'b1;
        cursor_x <= box_min_x;
        for (int i = 0; i < 3; i++) begin
          edge_row[i] <= edge_row[i] + EW'(row_step[i]);
          edge_val[i] <= edge_row[i] + EW'(row_step[i]);
        end
        row_base <= row_base + AW'(screen_width);
      end
    end
  end

  // Result register: every accepted word yields one result on the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      pixel_valid   <= cmd.step;
      write_enable  <= cmd.step && inside_all;
      pixel_address <= cmd.step ? (row_base + AW'(cursor_x)) : '0;
      pixel_color   <= cmd.step ? fill_color : '0;
      last          <= cmd.step && at_end;
    end
  end

endmodule
`default_nettype wire

[src/triangle_edge_rasterizer_unit.sv]
// Top level of the half-space triangle rasterizer: controller plus datapath.
//
// Usage: an input word is taken at a rising edge where start is high and busy
// is low. With action low the word loads a triangle (three signed vertices and
// a color); with action high it steps to the next pixel of the loaded box.
// Every accepted word produces exactly one result on the next cycle, shown for a
// single cycle with done high. A load result has all fields zero; a step made
// while no triangle is active also returns zeros.
// A load holds busy high while it forms and clips the bounding box, feeds the
// shared setup multiplier (an X and a Y product per edge and the row base
// address) and drains its pipeline. When the clipped box is empty, busy drops
// once the box has been checked and the block stays idle. Once set up, a step
// word is accepted every cycle, so pixels come out at one per clock in raster
// order, the final one flagged by last.
// Loading while a triangle is being drawn drops the old triangle.
// The screen_width and screen_height registers are written through cfg_write,
// cfg_index and cfg_data, and should only change while the block is idle.
// Reset (rst, synchronous) restores 640 by 400 and leaves no triangle active.
// There is no output back-pressure: the receiver must take each result.
`default_nettype none
module triangle_edge_rasterizer_unit #(
  parameter int COORD_BITS = ter_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                action,
  input  wire logic signed [COORD_BITS-1:0]        x0,
  input  wire logic signed [COORD_BITS-1:0]        y0,
  input  wire logic signed [COORD_BITS-1:0]        x1,
  input  wire logic signed [COORD_BITS-1:0]        y1,
  input  wire logic signed [COORD_BITS-1:0]        x2,
  input  wire logic signed [COORD_BITS-1:0]        y2,
  input  wire logic [ter_pkg::COLOR_BITS-1:0]      color,
  input  wire logic                                cfg_write,
  input  wire logic [ter_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [ter_pkg::DIM_BITS-1:0]        cfg_data,
  output logic                                     done,
  output logic                                     pixel_valid,
  output logic                                     write_enable,
  output logic [ter_pkg::ADDR_BITS-1:0]            pixel_address,
  output logic [ter_pkg::COLOR_BITS-1:0]           pixel_color,
  output logic                                     last
);

  // Commands flow from the controller to the datapath, status flows back.
  ter_pkg::ctrl_cmd_t    cmd;
  ter_pkg::ctrl_status_t status;

  ter_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  ter_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .x0            (x0),
    .y0            (y0),
    .x1            (x1),
    .y1            (y1),
    .x2            (x2),
    .y2            (y2),
    .color         (color),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .pixel_valid   (pixel_valid),
    .write_enable  (write_enable),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last          (last)
  );

`ifndef SYNTH
  // Each accepted word yields its result on the very next cycle.
  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted word produced no result");

  // No result appears without an accepted word.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without an accepted word");

  // A result that visits no pixel carries all-zero pixel fields.
  a_idle_result_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !pixel_valid) |-> (!write_enable && !last && (pixel_address == '0) &&
                                (pixel_color == '0)))
    else $error("pixel fields set on a result without a pixel");

  // The final pixel leaves the block idle and ready.
  a_last_then_ready: assert property (@(posedge clk) disable iff (rst)
    (done && last) |-> (pixel_valid && !busy))
    else $error("last pixel did not end the triangle");
`endif

endmodule
`default_nettype wire
